/* rtl/core/pfa_pkg.sv */
// Shared types and constants for the pool free-list allocator.
`timescale 1ns / 1ps

package pfa_pkg;

  // Pool geometry and field widths.
  localparam int POOL_CHUNKS = 256;
  localparam int MEM_AW      = $clog2(POOL_CHUNKS);
  localparam int PTR_W       = MEM_AW + 1;
  localparam int ADDR_W      = 32;
  localparam int SHIFT_W     = 5;
  localparam int COUNT_W     = 9;
  localparam int REQ_W       = 17;
  localparam int CFG_IDX_W   = 2;

  // The link value that marks an empty list or the end of the list.
  localparam logic [PTR_W-1:0] EMPTY_PTR = PTR_W'(POOL_CHUNKS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NONE    = 3'd1,
    ST_LARGE   = 3'd2,
    ST_NOHEAP  = 3'd3,
    ST_BADFREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ADDR_NONE = 2'd0,
    ADDR_HEAD = 2'd1,
    ADDR_CUR  = 2'd2
  } addr_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INIT,
    S_LINK_HEAD,
    S_WALK_CHECK,
    S_WALK_LINK
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [REQ_W-1:0]   request_size;
    logic [SHIFT_W-1:0] align_shift;
    logic [ADDR_W-1:0]  free_address;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] chunk_address;
    logic [2:0]        status;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  heap_base;
    logic [SHIFT_W-1:0] chunk_shift;
    logic [COUNT_W-1:0] chunk_count;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      latch;
    logic      rd_head;
    logic      rd_cur;
    logic      head_from_link;
    logic      head_clear;
    logic      head_zero;
    logic      head_push;
    logic      walk_start;
    logic      walk_adv;
    logic      unlink;
    logic      init_start;
    logic      init_step;
    logic      finish;
    status_t   fin_status;
    addr_sel_t addr_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic heap_zero;
    logic pool_empty;
    logic too_large;
    logic head_empty;
    logic free_bad;
    logic aligned;
    logic cur_end;
    logic init_last;
  } stat_t;

endpackage

/* rtl/core/pfa_cfg_regs.sv */
// Configuration registers of the pool allocator.
`timescale 1ns / 1ps

module pfa_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::ADDR_W-1:0]    cfg_data,
  output pfa_pkg::cfg_t                 cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base   <= '0;
      cfg.chunk_shift <= pfa_pkg::SHIFT_W'(4);
      cfg.chunk_count <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pfa_pkg::CFG_HEAP_BASE:   cfg.heap_base   <= cfg_data;
        pfa_pkg::CFG_CHUNK_SHIFT: cfg.chunk_shift <= cfg_data[pfa_pkg::SHIFT_W-1:0];
        pfa_pkg::CFG_CHUNK_COUNT: cfg.chunk_count <= cfg_data[pfa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/pfa_datapath.sv */
// Datapath of the pool allocator: head pointer, link memory, walk and result registers.
`timescale 1ns / 1ps

module pfa_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pfa_pkg::cfg_t     cfg,
  input  pfa_pkg::request_t request,
  input  pfa_pkg::cmd_t     cmd,
  output pfa_pkg::stat_t    stat,
  output logic              result_valid,
  output pfa_pkg::result_t  result
);

  localparam int AW = pfa_pkg::ADDR_W;
  localparam int PW = pfa_pkg::PTR_W;
  localparam int MW = pfa_pkg::MEM_AW;

  pfa_pkg::request_t req_q;
  logic [AW:0]       off_q;
  logic [PW-1:0]     head;
  logic [PW-1:0]     cur;
  logic [PW-1:0]     prev;
  logic [PW-1:0]     steps;
  logic [PW-1:0]     init_i;
  logic [PW-1:0]     init_next;
  logic [PW-1:0]     pool_n;
  logic [AW:0]       size_lim;
  logic [AW-1:0]     chunk_mask;
  logic [AW-1:0]     free_idx_full;
  logic [MW-1:0]     free_idx;
  logic [MW-1:0]     addr_idx;
  logic [AW-1:0]     chunk_addr;
  logic [PW-1:0]     link_mem [pfa_pkg::POOL_CHUNKS];
  logic [PW-1:0]     rd_data;
  logic              rd_en;
  logic [MW-1:0]     rd_addr;
  logic              wr_en;
  logic [MW-1:0]     wr_addr;
  logic [PW-1:0]     wr_data;

  // Capture the request and the offset of the freed address from the heap base.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= request;
      off_q <= {1'b0, request.free_address} - {1'b0, cfg.heap_base};
    end
  end

  // Pool size is the chunk count clamped to the pool depth.
  assign pool_n = (cfg.chunk_count > pfa_pkg::COUNT_W'(pfa_pkg::POOL_CHUNKS)) ?
                  pfa_pkg::EMPTY_PTR : PW'(cfg.chunk_count);

  // Request size limit and free-address checks.
  assign size_lim      = (AW + 1)'(1) << cfg.chunk_shift;
  assign chunk_mask    = ~({AW{1'b1}} << cfg.chunk_shift);
  assign free_idx_full = off_q[AW-1:0] >> cfg.chunk_shift;
  assign free_idx      = free_idx_full[MW-1:0];

  // Shared chunk address unit and alignment test.
  assign addr_idx   = (cmd.addr_sel == pfa_pkg::ADDR_CUR) ? cur[MW-1:0] : head[MW-1:0];
  assign chunk_addr = cfg.heap_base + (AW'(addr_idx) << cfg.chunk_shift);

  // Init sweep counter values.
  assign init_next = init_i + PW'(1);

  // Status to the controller.
  always_comb begin
    stat.op         = req_q.op;
    stat.heap_zero  = (cfg.heap_base == '0);
    stat.pool_empty = (pool_n == '0);
    stat.too_large  = ((AW + 1)'(req_q.request_size) > size_lim);
    stat.head_empty = (head >= pfa_pkg::EMPTY_PTR);
    stat.free_bad   = off_q[AW] || (|(off_q[AW-1:0] & chunk_mask)) ||
                      (free_idx_full >= AW'(pool_n));
    stat.aligned    = ((chunk_addr & ~({AW{1'b1}} << req_q.align_shift)) == '0);
    stat.cur_end    = (cur >= pfa_pkg::EMPTY_PTR) ||
                      (steps >= PW'(pfa_pkg::POOL_CHUNKS));
    stat.init_last  = (init_next == pool_n);
  end

  // Head pointer of the free list.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= pfa_pkg::EMPTY_PTR;
    end else begin
      priority if (cmd.head_from_link) begin
        head <= rd_data;
      end else if (cmd.head_clear) begin
        head <= pfa_pkg::EMPTY_PTR;
      end else if (cmd.head_zero) begin
        head <= '0;
      end else if (cmd.head_push) begin
        head <= PW'(free_idx);
      end
    end
  end

  // Walk registers for the alignment search.
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cur   <= rd_data;
      prev  <= head;
      steps <= '0;
    end else if (cmd.walk_adv) begin
      cur   <= rd_data;
      prev  <= cur;
      steps <= steps + PW'(1);
    end
  end

  // Init sweep counter.
  always_ff @(posedge clk) begin
    if (cmd.init_start) begin
      init_i <= '0;
    end else if (cmd.init_step) begin
      init_i <= init_next;
    end
  end

  // Link memory port selection.
  assign rd_en   = cmd.rd_head | cmd.rd_cur;
  assign rd_addr = cmd.rd_cur ? cur[MW-1:0] : head[MW-1:0];

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    priority if (cmd.head_push) begin
      wr_addr = free_idx;
      wr_data = head;
    end else if (cmd.unlink) begin
      wr_addr = prev[MW-1:0];
      wr_data = rd_data;
    end else if (cmd.init_step) begin
      wr_addr = init_i[MW-1:0];
      wr_data = (init_next < pool_n) ? init_next : pfa_pkg::EMPTY_PTR;
    end else begin
      wr_en = 1'b0;
    end
  end

  // Link memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= link_mem[rd_addr];
    end
  end

  // Result registers and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status        <= cmd.fin_status;
      result.chunk_address <= (cmd.addr_sel != pfa_pkg::ADDR_NONE) ? chunk_addr : '0;
    end
  end

endmodule

/* rtl/core/pfa_ctrl.sv */
// Controller state machine of the pool allocator.
`timescale 1ns / 1ps

module pfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pfa_pkg::stat_t stat,
  output pfa_pkg::cmd_t  cmd
);

  pfa_pkg::state_t state;
  pfa_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != pfa_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pfa_pkg::S_IDLE: begin
        if (start) state_next = pfa_pkg::S_EXEC;
      end
      pfa_pkg::S_EXEC: begin
        state_next = pfa_pkg::S_IDLE;
        if (stat.op == pfa_pkg::OP_INIT && !stat.heap_zero && !stat.pool_empty) begin
          state_next = pfa_pkg::S_INIT;
        end else if (stat.op == pfa_pkg::OP_ALLOC && !stat.too_large && !stat.head_empty) begin
          state_next = pfa_pkg::S_LINK_HEAD;
        end
      end
      pfa_pkg::S_INIT: begin
        if (stat.init_last) state_next = pfa_pkg::S_IDLE;
      end
      pfa_pkg::S_LINK_HEAD: begin
        state_next = stat.aligned ? pfa_pkg::S_IDLE : pfa_pkg::S_WALK_CHECK;
      end
      pfa_pkg::S_WALK_CHECK: begin
        state_next = stat.cur_end ? pfa_pkg::S_IDLE : pfa_pkg::S_WALK_LINK;
      end
      pfa_pkg::S_WALK_LINK: begin
        state_next = stat.aligned ? pfa_pkg::S_IDLE : pfa_pkg::S_WALK_CHECK;
      end
      default: state_next = pfa_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state)
      pfa_pkg::S_IDLE: begin
        cmd.latch = start;
      end
      pfa_pkg::S_EXEC: begin
        unique case (stat.op)
          pfa_pkg::OP_INIT: begin
            if (stat.heap_zero) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = pfa_pkg::ST_NOHEAP;
            end else if (stat.pool_empty) begin
              cmd.head_clear = 1'b1;
              cmd.finish     = 1'b1;
            end else begin
              cmd.init_start = 1'b1;
            end
          end
          pfa_pkg::OP_ALLOC: begin
            if (stat.too_large) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = pfa_pkg::ST_LARGE;
            end else if (stat.head_empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = pfa_pkg::ST_NONE;
            end else begin
              cmd.rd_head = 1'b1;
            end
          end
          pfa_pkg::OP_FREE: begin
            cmd.finish = 1'b1;
            if (stat.free_bad) begin
              cmd.fin_status = pfa_pkg::ST_BADFREE;
            end else begin
              cmd.head_push = 1'b1;
            end
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      pfa_pkg::S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) begin
          cmd.head_zero = 1'b1;
          cmd.finish    = 1'b1;
        end
      end
      pfa_pkg::S_LINK_HEAD: begin
        // The head's link has arrived; take the head or start searching.
        cmd.addr_sel = pfa_pkg::ADDR_HEAD;
        if (stat.aligned) begin
          cmd.head_from_link = 1'b1;
          cmd.finish         = 1'b1;
        end else begin
          cmd.walk_start = 1'b1;
        end
      end
      pfa_pkg::S_WALK_CHECK: begin
        if (stat.cur_end) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = pfa_pkg::ST_NONE;
        end else begin
          cmd.rd_cur = 1'b1;
        end
      end
      pfa_pkg::S_WALK_LINK: begin
        // The current chunk's link has arrived; unlink it or step on.
        cmd.addr_sel = pfa_pkg::ADDR_CUR;
        if (stat.aligned) begin
          cmd.unlink = 1'b1;
          cmd.finish = 1'b1;
        end else begin
          cmd.walk_adv = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/pool_free_list_allocator_core.sv */
// Top level of the fixed-size pool allocator with a free list of chunk indices.
//
// A request is taken when start is high and busy is low. The request carries
// op (init, allocate, free), request_size, align_shift and free_address.
// Every request gives exactly one result: result_valid is high for one cycle
// with chunk_address and status, and the receiver must take it then.
// Steps after a request is accepted, with busy high until the result shows:
//   free, failed checks, no-op: the execute state decides and gives the result.
//   allocate from the head: execute reads the head's link from the link memory,
//     and the head state takes it as the new head. A search walks check and link
//     states over the chunks skipped on the list, since each step needs one
//     registered read of the link memory; a failed search ends in the check state.
//   init: one link memory word written per cycle, pool size words in all.
// A new request may be accepted in the cycle the previous result is shown.
// Configuration writes (index 0 heap base, 1 chunk shift, 2 chunk count) go
// through cfg_valid/cfg_ready, are always ready, and belong to idle periods.
// Reset empties the free list and loads the register reset values; the link
// memory is not cleared, and an init request builds the list.
`timescale 1ns / 1ps

module pool_free_list_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pfa_pkg::request_t             request,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::ADDR_W-1:0]    cfg_data,
  output logic                          result_valid,
  output pfa_pkg::result_t              result
);

  pfa_pkg::cfg_t  cfg;
  pfa_pkg::cmd_t  cmd;
  pfa_pkg::stat_t stat;

  // Configuration registers.
  pfa_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Controller.
  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath.
  pfa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .request      (request),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* dv/tb_pool_free_list_allocator_core.sv */
// Self-checking testbench for the pool free-list allocator core.
`timescale 1ns / 1ps

module tb_pool_free_list_allocator_core;
  import pfa_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEM_GOAL     = 1900;

  typedef enum logic [1:0] {
    JOB_REQ,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_t;

  typedef struct packed {
    job_kind_t            kind;
    request_t             req;
    logic [CFG_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    data;
  } job_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  request_t             request   = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;
  logic                 busy;
  logic                 cfg_ready;
  logic                 result_valid;
  result_t              result;

  // Jobs waiting for the driver, results the block still owes.
  job_t                 job_queue[$];
  result_t              pending_results[$];
  // Chunks that are out on loan, as the predicted allocations say.
  logic [ADDR_W-1:0]    held_chunks[$];

  // Shadow copy of the registers and the free list.
  logic [ADDR_W-1:0]    cfg_base  = '0;
  logic [SHIFT_W-1:0]   cfg_shift = 5'd4;
  logic [COUNT_W-1:0]   cfg_count = '0;
  logic [PTR_W-1:0]     list_head = EMPTY_PTR;
  logic [PTR_W-1:0]     chunk_link[POOL_CHUNKS];

  logic                 req_taken   = 1'b0;
  logic                 cfg_taken   = 1'b0;
  int                   idle_cycles = 0;
  int                   quiet_cycles = 0;
  int                   gap_left    = 0;
  int                   burst_left  = 0;
  int                   mismatch_count = 0;
  int                   items_sent  = 0;
  bit                   timed_out   = 1'b0;

  pool_free_list_allocator_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < POOL_CHUNKS; i++) chunk_link[i[MEM_AW-1:0]] = '0;
  end

  // Byte address of a chunk under the current registers, wrapping at 32 bits.
  function automatic logic [ADDR_W-1:0] chunk_at(logic [PTR_W-1:0] idx);
    logic [63:0] sum;
    sum = 64'(cfg_base) + (64'(idx) << cfg_shift);
    return sum[ADDR_W-1:0];
  endfunction

  function automatic bit is_aligned(logic [ADDR_W-1:0] a, logic [SHIFT_W-1:0] sh);
    return (64'(a) & ((64'd1 << sh) - 64'd1)) == 64'd0;
  endfunction

  // Applies one request to the shadow free list and returns the result it gives.
  function automatic result_t pool_outcome(request_t rq);
    logic [63:0]        addr, a, b, off, idx, csize;
    logic [PTR_W-1:0]   prev, cur, steps, npool;
    status_t            st;
    bit                 found;
    int                 i;
    result_t            res;
    addr  = '0;
    st    = ST_OK;
    npool = (cfg_count > COUNT_W'(POOL_CHUNKS)) ? PTR_W'(POOL_CHUNKS) : cfg_count;
    csize = 64'd1 << cfg_shift;
    case (rq.op)
      OP_INIT: begin
        if (cfg_base == '0) begin
          st = ST_NOHEAP;
        end else begin
          for (i = 0; i < int'(npool); i++) begin
            chunk_link[i[MEM_AW-1:0]] = (i + 1 < int'(npool)) ? PTR_W'(i + 1) : EMPTY_PTR;
          end
          list_head = (npool != '0) ? '0 : EMPTY_PTR;
          held_chunks.delete();
        end
      end
      OP_ALLOC: begin
        if (64'(rq.request_size) > csize) begin
          st = ST_LARGE;
        end else if (list_head[PTR_W-1]) begin
          st = ST_NONE;
        end else if (is_aligned(chunk_at(list_head), rq.align_shift)) begin
          addr      = 64'(chunk_at(list_head));
          list_head = chunk_link[list_head[MEM_AW-1:0]];
        end else begin
          // Walk the list for the first aligned chunk, bounded for looped lists.
          st    = ST_NONE;
          found = 1'b0;
          prev  = list_head;
          cur   = chunk_link[prev[MEM_AW-1:0]];
          steps = '0;
          while (!found && !cur[PTR_W-1] && steps < PTR_W'(POOL_CHUNKS)) begin
            if (is_aligned(chunk_at(cur), rq.align_shift)) begin
              chunk_link[prev[MEM_AW-1:0]] = chunk_link[cur[MEM_AW-1:0]];
              addr  = 64'(chunk_at(cur));
              st    = ST_OK;
              found = 1'b1;
            end else begin
              prev  = cur;
              cur   = chunk_link[cur[MEM_AW-1:0]];
              steps = steps + PTR_W'(1);
            end
          end
        end
        if (st == ST_OK) held_chunks.push_back(addr[ADDR_W-1:0]);
      end
      OP_FREE: begin
        a   = 64'(rq.free_address);
        b   = 64'(cfg_base);
        off = (a - b) & 64'hFFFF_FFFF;
        idx = off >> cfg_shift;
        if (a < b || (off & (csize - 64'd1)) != 64'd0 || idx >= 64'(npool)) begin
          st = ST_BADFREE;
        end else begin
          chunk_link[idx[MEM_AW-1:0]] = list_head;
          list_head = PTR_W'(idx);
        end
      end
      default: begin
      end
    endcase
    res.chunk_address = addr[ADDR_W-1:0];
    res.status        = st;
    return res;
  endfunction

  // Driver: presents requests in bursts, holds register writes until the block is quiet.
  always @(negedge clk) begin : drive
    logic drive_start;
    logic drive_cfg;
    job_t job;
    drive_start = start;
    drive_cfg   = cfg_valid;
    if (!rst) begin
      if (pending_results.size() == 0 && !busy && !start && !cfg_valid) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      if (start && req_taken) drive_start = 1'b0;
      if (cfg_valid && cfg_taken) drive_cfg = 1'b0;
      if (!drive_start && !drive_cfg && job_queue.size() != 0) begin
        if (job_queue[0].kind == JOB_REQ) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            job         = job_queue.pop_front();
            request    <= job.req;
            drive_start = 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(1, 24);
            burst_left--;
            if (burst_left == 0) begin
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
          end
        end else if (quiet_cycles >= SETTLE_CYCLES) begin
          job = job_queue.pop_front();
          if (job.kind == JOB_CFG) begin
            cfg_index <= job.idx;
            cfg_data  <= job.data;
            drive_cfg  = 1'b1;
          end
        end
      end
      start     <= drive_start;
      cfg_valid <= drive_cfg;
    end
  end

  // Monitor: checks each result against the oldest expectation, then predicts new requests.
  always @(posedge clk) begin : observe
    result_t want;
    if (rst) begin
      req_taken   <= 1'b0;
      cfg_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: address %h status %0d",
                     result.chunk_address, result.status);
          end
        end else begin
          want = pending_results.pop_front();
          if (result.chunk_address !== want.chunk_address || result.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch: expected address %h status %0d, got address %h status %0d",
                       want.chunk_address, want.status, result.chunk_address, result.status);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEAP_BASE:   cfg_base  = cfg_data;
          CFG_CHUNK_SHIFT: cfg_shift = cfg_data[SHIFT_W-1:0];
          CFG_CHUNK_COUNT: cfg_count = cfg_data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (start && !busy) pending_results.push_back(pool_outcome(request));
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Keeps the job queue short so that frees can use chunks from recent allocations.
  task automatic push_job(job_t j);
    while (job_queue.size() >= 2) @(negedge clk);
    job_queue.push_back(j);
  endtask

  task automatic push_req(op_t op, logic [REQ_W-1:0] size, logic [SHIFT_W-1:0] ash,
                          logic [ADDR_W-1:0] faddr);
    job_t j;
    j.kind             = JOB_REQ;
    j.req.op           = op;
    j.req.request_size = size;
    j.req.align_shift  = ash;
    j.req.free_address = faddr;
    j.idx              = '0;
    j.data             = '0;
    push_job(j);
    items_sent++;
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    job_t j;
    j.kind = JOB_CFG;
    j.req  = '0;
    j.idx  = idx;
    j.data = data;
    push_job(j);
  endtask

  task automatic push_drain();
    job_t j;
    j      = '0;
    j.kind = JOB_DRAIN;
    push_job(j);
  endtask

  initial begin : main
    int unsigned       g_shift, g_count, r, r2, n, k, ash, size;
    logic [ADDR_W-1:0] g_base, mask, faddr, last_freed;
    last_freed = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    fork
      begin
        // Directed part, starting from the register reset values.
        push_req(OP_ALLOC, 17'd17, 5'd0, $urandom());         // too large for 16-byte chunks
        push_req(OP_ALLOC, 17'd16, 5'($urandom()), $urandom()); // empty list
        push_req(OP_INIT, 17'($urandom_range(0, 65536)), 5'($urandom()), $urandom()); // no heap
        push_req(OP_FREE, 17'd0, 5'd0, 32'h0);                // nothing in the pool yet
        push_req(OP_NOP, 17'h10000, 5'd31, 32'hFFFF_FFFF);
        push_cfg(CFG_HEAP_BASE, 32'h0000_1000);
        push_req(OP_INIT, 17'd0, 5'd0, 32'h0);                // empty pool
        push_req(OP_ALLOC, 17'd0, 5'd0, 32'h0);
        push_cfg(CFG_CHUNK_COUNT, 32'd4);
        push_req(OP_INIT, 17'd0, 5'd0, 32'h0);
        push_req(OP_ALLOC, 17'd0, 5'd0, 32'h0);
        push_req(OP_ALLOC, 17'd16, 5'd5, 32'h0);              // head misaligned, search hits
        push_req(OP_ALLOC, 17'd8, 5'd31, 32'h0);              // search fails
        push_req(OP_FREE, 17'd0, 5'd0, 32'h0000_1000);
        push_req(OP_FREE, 17'd0, 5'd0, 32'h0000_1020);
        push_req(OP_FREE, 17'd0, 5'd0, 32'h0000_1008);        // off a chunk boundary
        push_req(OP_FREE, 17'd0, 5'd0, 32'h0000_0FF0);        // below the heap
        push_req(OP_FREE, 17'd0, 5'd0, 32'h0000_1040);        // past the last chunk
        push_req(OP_FREE, 17'd0, 5'd0, 32'h0000_1020);        // double free makes a loop
        push_req(OP_ALLOC, 17'd1, 5'd31, 32'h0);              // search gives up on the loop
        push_req(OP_ALLOC, 17'd1, 5'd4, 32'h0);
        push_cfg(CFG_HEAP_BASE, 32'h0000_2000);               // new base without a new init
        push_req(OP_ALLOC, 17'd0, 5'd0, 32'h0);
        push_cfg(CFG_HEAP_BASE, 32'hFFFF_0000);
        push_cfg(CFG_CHUNK_SHIFT, 32'd16);
        push_cfg(CFG_CHUNK_COUNT, 32'd511);                   // clamps to the pool size
        push_req(OP_INIT, 17'd0, 5'd0, 32'h0);
        push_req(OP_ALLOC, 17'h10000, 5'd16, 32'h0);
        push_req(OP_ALLOC, 17'h10000, 5'd31, 32'h0);          // wrapped chunk at address zero
        push_req(OP_FREE, 17'd0, 5'd0, 32'hFFFF_0000);
        push_req(OP_FREE, 17'd0, 5'd0, 32'h0000_0000);
        push_cfg(CFG_HEAP_BASE, 32'h0000_0004);
        push_cfg(CFG_CHUNK_SHIFT, 32'd2);
        push_cfg(CFG_CHUNK_COUNT, 32'd256);
        push_req(OP_INIT, 17'd0, 5'd0, 32'h0);
        push_req(OP_ALLOC, 17'd4, 5'd3, 32'h0);
        push_req(OP_ALLOC, 17'd5, 5'd0, 32'h0);

        // Random phases: register settings, in most phases an init, then allocate/free traffic.
        while (items_sent < ITEM_GOAL) begin
          r = $urandom_range(0, 7);
          g_shift = (r == 0) ? 2 : (r == 1) ? 16 : $urandom_range(2, 16);
          r = $urandom_range(0, 19);
          g_count = (r == 0) ? 0 : (r == 1) ? 256 : (r == 2) ? $urandom_range(100, 256)
                                                             : $urandom_range(1, 32);
          mask = (32'd1 << g_shift) - 32'd1;
          r = $urandom_range(0, 11);
          case (r)
            0:       g_base = '0;
            1:       g_base = $urandom();
            2:       g_base = 32'hFFFF_FFFF & ~mask;
            default: g_base = $urandom() & ~mask;
          endcase
          if ($urandom_range(0, 4) == 0) begin
            // Only one register changes; the others keep what the block holds.
            case ($urandom_range(0, 2))
              0: begin
                push_cfg(CFG_HEAP_BASE, g_base);
                g_shift = 32'(cfg_shift);
                g_count = 32'(cfg_count);
              end
              1: begin
                push_cfg(CFG_CHUNK_SHIFT, 32'(g_shift));
                g_base  = cfg_base;
                g_count = 32'(cfg_count);
              end
              default: begin
                push_cfg(CFG_CHUNK_COUNT, 32'(g_count));
                g_base  = cfg_base;
                g_shift = 32'(cfg_shift);
              end
            endcase
            mask = (32'd1 << g_shift) - 32'd1;
          end else begin
            push_cfg(CFG_HEAP_BASE, g_base);
            push_cfg(CFG_CHUNK_SHIFT, 32'(g_shift));
            push_cfg(CFG_CHUNK_COUNT, 32'(g_count));
          end
          if ($urandom_range(0, 5) != 0) push_req(OP_INIT, 17'($urandom_range(0, 65536)),
                                                  5'($urandom()), $urandom());
          n = $urandom_range(40, 110);
          for (int it = 0; it < int'(n); it++) begin
            r  = $urandom_range(0, 99);
            r2 = $urandom_range(0, 99);
            if (r < 45) begin
              if (r2 < 60) begin
                ash = $urandom_range(0, g_shift);
              end else if (r2 < 90) begin
                ash = $urandom_range(g_shift + 1, (g_shift + 4 > 31) ? 31 : g_shift + 4);
              end else begin
                ash = $urandom_range(0, 31);
              end
              r2 = $urandom_range(0, 99);
              if (r2 < 85) begin
                size = $urandom_range(0, 1 << g_shift);
              end else if (r2 < 95) begin
                size = (g_shift < 16) ? $urandom_range((1 << g_shift) + 1, 65536) : 65536;
              end else begin
                size = ($urandom_range(0, 1) == 0) ? 0 : 65536;
              end
              push_req(OP_ALLOC, 17'(size), 5'(ash), $urandom());
            end else if (r < 80) begin
              if (held_chunks.size() != 0 && r2 < 75) begin
                k = $urandom_range(0, held_chunks.size() - 1);
                faddr = held_chunks[k];
                held_chunks.delete(k);
              end else begin
                k = $urandom_range(0, (g_count > 0) ? g_count - 1 : 0);
                case (r2 % 5)
                  0: faddr = $urandom();
                  1: faddr = g_base + (32'(k) << g_shift) + 32'($urandom_range(1, mask));
                  2: faddr = g_base + (32'(g_count + $urandom_range(0, 3)) << g_shift);
                  3: faddr = g_base - 32'($urandom_range(1, 64));
                  default: faddr = last_freed;
                endcase
              end
              last_freed = faddr;
              push_req(OP_FREE, 17'($urandom_range(0, 65536)), 5'($urandom()), faddr);
            end else if (r < 84) begin
              push_req(OP_INIT, 17'($urandom_range(0, 65536)), 5'($urandom()), $urandom());
            end else if (r < 88) begin
              push_req(OP_NOP, 17'($urandom_range(0, 65536)), 5'($urandom()), $urandom());
            end else if (r < 90) begin
              push_drain();
            end else begin
              push_req(OP_ALLOC, 17'($urandom_range(0, 65536)), 5'($urandom()), $urandom());
            end
          end
        end

        // Let everything finish, then wait on for stray results.
        while (job_queue.size() != 0 || start || cfg_valid || pending_results.size() != 0) begin
          @(negedge clk);
        end
        repeat (20) @(posedge clk);
      end
      begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
